// File: hw/rtl/sdsc_pkg.sv
package sdsc_pkg;

  localparam int unsigned BUFFER_BYTES   = 512;
  localparam int unsigned REGISTER_COUNT = 20;

  localparam logic [15:0] WIN_LO = 16'hDE00;
  localparam logic [15:0] WIN_HI = 16'hDFFF;

  localparam logic [7:0] ST_RESET  = 8'h04;
  localparam logic [7:0] ST_MAPPED = 8'h08;
  localparam logic [7:0] ST_HC     = 8'h10;
  localparam logic [7:0] ST_FSMERR = 8'h20;
  localparam logic [7:0] ST_ERR    = 8'h40;
  localparam logic [7:0] ST_EXT    = 8'h80;

  localparam logic [7:0] CMD_RESET0 = 8'h00;
  localparam logic [7:0] CMD_RESET1 = 8'h10;
  localparam logic [7:0] CMD_END0   = 8'h01;
  localparam logic [7:0] CMD_END1   = 8'h11;
  localparam logic [7:0] CMD_READ   = 8'h02;
  localparam logic [7:0] CMD_WRITE  = 8'h03;
  localparam logic [7:0] CMD_FLASH  = 8'h53;
  localparam logic [7:0] CMD_INT0   = 8'h40;
  localparam logic [7:0] CMD_INT1   = 8'hC0;
  localparam logic [7:0] CMD_EXT    = 8'hC1;
  localparam logic [7:0] CMD_MAP    = 8'h81;
  localparam logic [7:0] CMD_UNMAP  = 8'h82;

  localparam logic [1:0] CFG_BASE     = 2'd0;
  localparam logic [1:0] CFG_MOUNTED  = 2'd1;
  localparam logic [1:0] CFG_WRITABLE = 2'd2;
  localparam logic [1:0] CFG_SECTORS  = 2'd3;

  typedef enum logic [2:0] {
    ACT_BUS_READ  = 3'd0,
    ACT_BUS_WRITE = 3'd1,
    ACT_FILL      = 3'd2,
    ACT_FETCH     = 3'd3,
    ACT_DONE      = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    PK_NONE  = 2'd0,
    PK_READ  = 2'd1,
    PK_WRITE = 2'd2,
    PK_FLASH = 2'd3
  } pend_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACCESS,
    S_SWEEP,
    S_OUT,
    S_CLEAR
  } state_t;

endpackage

// File: hw/rtl/sdsc_buffer.sv
module sdsc_buffer #(
  parameter int unsigned BufferBytes = sdsc_pkg::BUFFER_BYTES,
  localparam int unsigned AW = $clog2(BufferBytes)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [BufferBytes];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/sd_card_sector_controller.sv
// SD card sector controller: byte registers at cfg base_address (offset zero is
// status/command) and a 512-byte sector buffer window at 0xDE00-0xDFFF. One
// word at a time: a word is latched in S_IDLE, handled in S_ACCESS, where the
// registered buffer RAM read is ready, and held in S_OUT until taken. Commands
// that clear or 0xFF-fill the buffer, and a failed flash-read done, sweep the
// buffer RAM one byte per cycle in S_SWEEP ahead of S_OUT. After reset the
// buffer RAM is cleared the same way, so the input stays stalled until the clear
// is done. Sector requests leave on the out_request_* fields of the result word;
// storage then fills/fetches bytes and reports done on the same input channel.
module sd_card_sector_controller #(
  parameter int unsigned BufferBytes   = sdsc_pkg::BUFFER_BYTES,
  parameter int unsigned RegisterCount = sdsc_pkg::REGISTER_COUNT,
  localparam int unsigned AW = $clog2(BufferBytes),
  localparam int unsigned RW = $clog2(RegisterCount)
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [32:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_action,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_data,
  input  logic [8:0]  in_buffer_index,
  input  logic        in_storage_ok,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_handled,
  output logic [7:0]  out_read_data,
  output logic        out_request_valid,
  output logic        out_request_write,
  output logic [31:0] out_request_sector
);

  logic [15:0] base_r;
  logic        mounted_r, writable_r;
  logic [32:0] sectors_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r     <= '0;
      mounted_r  <= 1'b0;
      writable_r <= 1'b1;
      sectors_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        sdsc_pkg::CFG_BASE:     base_r     <= cfg_data[15:0];
        sdsc_pkg::CFG_MOUNTED:  mounted_r  <= cfg_data[0];
        sdsc_pkg::CFG_WRITABLE: writable_r <= cfg_data[0];
        sdsc_pkg::CFG_SECTORS:  sectors_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  sdsc_pkg::state_t state_r, state_nxt;
  sdsc_pkg::pend_t  pend_r, pend_nxt;
  logic [7:0]  status_r, status_nxt;
  logic        mapped_r, mapped_nxt;
  logic [7:0]  regs_r [RegisterCount];

  // latched word
  logic [2:0]  act_r;
  logic [15:0] addr_r;
  logic [7:0]  data_r;
  logic [8:0]  idx_r;
  logic        ok_r;

  logic [AW:0] sweep_r, sweep_nxt;
  logic [7:0]  fill_r, fill_nxt;

  logic        o_handled_r, o_handled_nxt, o_sel_mem_r, o_sel_mem_nxt;
  logic [7:0]  o_data_r, o_data_nxt;
  logic        o_rv_r, o_rv_nxt, o_rw_r, o_rw_nxt;
  logic [31:0] o_sec_r, o_sec_nxt;

  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata, mem_rdata;

  sdsc_buffer #(.BufferBytes(BufferBytes)) u_buf (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // decode of the latched word
  logic        win, reg_hit, cmd_wr, reg_wr;
  logic [16:0] roff_full;
  logic [RW-1:0] roff;
  logic [31:0] cur_sec;
  logic        in_img;

  always_comb begin
    win       = (addr_r >= sdsc_pkg::WIN_LO) && (addr_r <= sdsc_pkg::WIN_HI);
    roff_full = {1'b0, addr_r} - {1'b0, base_r};
    reg_hit   = (addr_r >= base_r) && (roff_full < 17'(RegisterCount));
    roff      = roff_full[RW-1:0];
    reg_wr    = (act_r == sdsc_pkg::ACT_BUS_WRITE) && !win && reg_hit;
    cmd_wr    = reg_wr && (roff == '0);
    cur_sec   = {regs_r[4], regs_r[3], regs_r[2], regs_r[1]};
    in_img    = {1'b0, cur_sec} < sectors_r;
  end

  assign in_stall  = (state_r != sdsc_pkg::S_IDLE);
  assign out_valid = (state_r == sdsc_pkg::S_OUT);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sdsc_pkg::S_IDLE:   if (in_valid) state_nxt = sdsc_pkg::S_ACCESS;
      sdsc_pkg::S_ACCESS: state_nxt = (sweep_nxt != '0) ? sdsc_pkg::S_SWEEP : sdsc_pkg::S_OUT;
      sdsc_pkg::S_SWEEP:  if (sweep_r == (AW+1)'(1)) state_nxt = sdsc_pkg::S_OUT;
      sdsc_pkg::S_OUT:    if (!out_stall) state_nxt = sdsc_pkg::S_IDLE;
      sdsc_pkg::S_CLEAR:  if (sweep_r == (AW+1)'(1)) state_nxt = sdsc_pkg::S_IDLE;
      default:            state_nxt = sdsc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    pend_nxt      = pend_r;
    status_nxt    = status_r;
    mapped_nxt    = mapped_r;
    sweep_nxt     = '0;
    fill_nxt      = fill_r;
    o_handled_nxt = o_handled_r;
    o_sel_mem_nxt = o_sel_mem_r;
    o_data_nxt    = o_data_r;
    o_rv_nxt      = o_rv_r;
    o_rw_nxt      = o_rw_r;
    o_sec_nxt     = o_sec_r;
    mem_we        = 1'b0;
    mem_waddr     = in_buffer_index[AW-1:0];
    mem_wdata     = data_r;
    mem_raddr     = (in_action == sdsc_pkg::ACT_FETCH) ? in_buffer_index[AW-1:0]
                                                       : in_address[AW-1:0];
    if (state_r == sdsc_pkg::S_ACCESS) begin
      o_handled_nxt = 1'b0;
      o_sel_mem_nxt = 1'b0;
      o_data_nxt    = '0;
      o_rv_nxt      = 1'b0;
      o_rw_nxt      = 1'b0;
      o_sec_nxt     = '0;
      case (act_r)
        sdsc_pkg::ACT_BUS_READ: begin
          if (win) begin
            o_handled_nxt = 1'b1;
            if (mapped_r) o_sel_mem_nxt = 1'b1;
            else          o_data_nxt    = 8'hFF;
          end else if (reg_hit) begin
            o_handled_nxt = 1'b1;
            o_data_nxt    = (roff == '0) ? status_r : regs_r[roff];
          end
        end
        sdsc_pkg::ACT_BUS_WRITE: begin
          if (win) begin
            o_handled_nxt = 1'b1;
            mem_we    = mapped_r;
            mem_waddr = addr_r[AW-1:0];
          end else if (reg_hit) begin
            o_handled_nxt = 1'b1;
          end
          if (cmd_wr) begin
            status_nxt = status_r & ~(sdsc_pkg::ST_ERR | sdsc_pkg::ST_FSMERR);
            case (data_r)
              sdsc_pkg::CMD_RESET0, sdsc_pkg::CMD_RESET1: begin
                status_nxt = sdsc_pkg::ST_RESET | sdsc_pkg::ST_HC;
                pend_nxt   = sdsc_pkg::PK_NONE;
              end
              sdsc_pkg::CMD_END0, sdsc_pkg::CMD_END1: status_nxt = sdsc_pkg::ST_HC;
              sdsc_pkg::CMD_READ: begin
                if (!mounted_r) begin
                  sweep_nxt = (AW+1)'(BufferBytes); fill_nxt = 8'h00;
                end else if (!in_img) begin
                  sweep_nxt = (AW+1)'(BufferBytes); fill_nxt = 8'h00;
                  status_nxt = status_nxt | sdsc_pkg::ST_ERR;
                end else begin
                  pend_nxt = sdsc_pkg::PK_READ; o_rv_nxt = 1'b1; o_sec_nxt = cur_sec;
                end
              end
              sdsc_pkg::CMD_WRITE: begin
                if (!mounted_r || !in_img || !writable_r) begin
                  status_nxt = status_nxt | sdsc_pkg::ST_ERR;
                end else begin
                  pend_nxt = sdsc_pkg::PK_WRITE; o_rv_nxt = 1'b1;
                  o_rw_nxt = 1'b1; o_sec_nxt = cur_sec;
                end
              end
              sdsc_pkg::CMD_FLASH: begin
                if (!mounted_r) begin
                  sweep_nxt = (AW+1)'(BufferBytes); fill_nxt = 8'h00;
                end else if (!in_img) begin
                  sweep_nxt = (AW+1)'(BufferBytes); fill_nxt = 8'hFF;
                end else begin
                  pend_nxt = sdsc_pkg::PK_FLASH; o_rv_nxt = 1'b1; o_sec_nxt = cur_sec;
                end
              end
              sdsc_pkg::CMD_INT0, sdsc_pkg::CMD_INT1:
                status_nxt = status_nxt & ~sdsc_pkg::ST_EXT;
              sdsc_pkg::CMD_EXT: status_nxt = status_nxt | sdsc_pkg::ST_EXT;
              sdsc_pkg::CMD_MAP: begin
                mapped_nxt = 1'b1; status_nxt = status_nxt | sdsc_pkg::ST_MAPPED;
              end
              sdsc_pkg::CMD_UNMAP: begin
                mapped_nxt = 1'b0; status_nxt = status_nxt & ~sdsc_pkg::ST_MAPPED;
              end
              default: ;
            endcase
          end
        end
        sdsc_pkg::ACT_FILL: begin
          mem_we    = (pend_r == sdsc_pkg::PK_READ) || (pend_r == sdsc_pkg::PK_FLASH);
          mem_waddr = idx_r[AW-1:0];
        end
        sdsc_pkg::ACT_FETCH: o_sel_mem_nxt = 1'b1;
        sdsc_pkg::ACT_DONE: begin
          if (pend_r != sdsc_pkg::PK_NONE && !ok_r) begin
            if (pend_r == sdsc_pkg::PK_FLASH) begin
              sweep_nxt = (AW+1)'(BufferBytes); fill_nxt = 8'hFF;
            end else begin
              status_nxt = status_r | sdsc_pkg::ST_ERR;
            end
          end
          pend_nxt = sdsc_pkg::PK_NONE;
        end
        default: ;
      endcase
      // capture the ram word read during the access cycle
      if (o_sel_mem_nxt) begin
        o_data_nxt    = mem_rdata;
        o_sel_mem_nxt = 1'b0;
      end
    end else if (state_r inside {sdsc_pkg::S_SWEEP, sdsc_pkg::S_CLEAR}) begin
      sweep_nxt = sweep_r - (AW+1)'(1);
      mem_we    = 1'b1;
      mem_waddr = sweep_nxt[AW-1:0];
      mem_wdata = fill_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      // buffer resets to zero: clear it before taking words
      state_r  <= sdsc_pkg::S_CLEAR;
      pend_r   <= sdsc_pkg::PK_NONE;
      status_r <= sdsc_pkg::ST_HC;
      mapped_r <= 1'b0;
      sweep_r  <= (AW+1)'(BufferBytes);
    end else begin
      state_r  <= state_nxt;
      pend_r   <= pend_nxt;
      status_r <= status_nxt;
      mapped_r <= mapped_nxt;
      sweep_r  <= sweep_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= 8'h00;
      for (int i = 0; i < int'(RegisterCount); i++) regs_r[i] <= '0;
    end else begin
      fill_r <= fill_nxt;
      if (state_r == sdsc_pkg::S_ACCESS && reg_wr) begin
        regs_r[roff] <= data_r;
        if (cmd_wr && (data_r == sdsc_pkg::CMD_RESET0 || data_r == sdsc_pkg::CMD_RESET1)) begin
          regs_r[1] <= '0; regs_r[2] <= '0; regs_r[3] <= '0; regs_r[4] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == sdsc_pkg::S_IDLE && in_valid) begin
      act_r  <= in_action;
      addr_r <= in_address;
      data_r <= in_data;
      idx_r  <= in_buffer_index;
      ok_r   <= in_storage_ok;
    end
    o_handled_r <= o_handled_nxt;
    o_sel_mem_r <= o_sel_mem_nxt;
    o_data_r    <= o_data_nxt;
    o_rv_r      <= o_rv_nxt;
    o_rw_r      <= o_rw_nxt;
    o_sec_r     <= o_sec_nxt;
  end

  assign out_handled        = o_handled_r;
  assign out_read_data      = o_data_r;
  assign out_request_valid  = o_rv_r;
  assign out_request_write  = o_rw_r;
  assign out_request_sector = o_sec_r;

`ifndef SYNTHESIS
  a_req_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_request_valid) |-> (pend_r != sdsc_pkg::PK_NONE))
    else $error("request without pending transfer");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_read_data) && $stable(out_request_sector)))
    else $error("stalled result word changed");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sdsc_pkg::S_SWEEP) |-> in_stall)
    else $error("word accepted during sweep");
`endif

endmodule

// File: tb/tb_sd_card_sector_controller.sv
`timescale 1ns / 1ps

module tb_sd_card_sector_controller;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] address;
    logic [7:0]  data;
    logic [8:0]  buffer_index;
    logic        storage_ok;
  } bus_word_t;

  typedef struct packed {
    logic        handled;
    logic [7:0]  read_data;
    logic        request_valid;
    logic        request_write;
    logic [31:0] request_sector;
  } reply_t;

  localparam int HOLD_CYCLES = 200;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [32:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_action = '0;
  logic [15:0] in_address = '0;
  logic [7:0]  in_data = '0;
  logic [8:0]  in_buffer_index = '0;
  logic        in_storage_ok = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_handled;
  logic [7:0]  out_read_data;
  logic        out_request_valid;
  logic        out_request_write;
  logic [31:0] out_request_sector;

  sd_card_sector_controller dut (.*);

  // model state
  logic [15:0] m_base;
  logic        m_mounted, m_writable;
  logic [32:0] m_sectors;
  logic [7:0]  model_st;
  logic [7:0]  m_regs [sdsc_pkg::REGISTER_COUNT];
  logic [7:0]  m_buf [sdsc_pkg::BUFFER_BYTES];
  logic        m_mapped;
  sdsc_pkg::pend_t m_pend;

  reply_t expected_replies[$];
  int     n_errors = 0;
  int     n_sent = 0;
  int     n_checked = 0;
  int     n_requests = 0;
  int     idle_cycles = 0;
  bit     long_hold = 1'b0;
  bit     random_out = 1'b1;

  initial forever #4 clk = ~clk;

  function automatic void fill_buffer(input logic [7:0] v);
    for (int i = 0; i < int'(sdsc_pkg::BUFFER_BYTES); i++) m_buf[i] = v;
  endfunction

  function automatic void model_command(input logic [7:0] cmd, inout reply_t r);
    logic [31:0] sec;
    logic        in_range;
    sec = {m_regs[4], m_regs[3], m_regs[2], m_regs[1]};
    in_range = {1'b0, sec} < m_sectors;
    model_st &= ~(sdsc_pkg::ST_ERR | sdsc_pkg::ST_FSMERR);
    case (cmd)
      sdsc_pkg::CMD_RESET0, sdsc_pkg::CMD_RESET1: begin
        model_st = sdsc_pkg::ST_RESET | sdsc_pkg::ST_HC;
        for (int i = 1; i <= 4; i++) m_regs[i] = '0;
        m_pend = sdsc_pkg::PK_NONE;
      end
      sdsc_pkg::CMD_END0, sdsc_pkg::CMD_END1: model_st = sdsc_pkg::ST_HC;
      sdsc_pkg::CMD_READ: begin
        if (!m_mounted) fill_buffer(8'h00);
        else if (!in_range) begin
          fill_buffer(8'h00);
          model_st |= sdsc_pkg::ST_ERR;
        end else begin
          m_pend = sdsc_pkg::PK_READ;
          r.request_valid = 1'b1;
          r.request_sector = sec;
        end
      end
      sdsc_pkg::CMD_WRITE: begin
        if (!m_mounted || !in_range || !m_writable) model_st |= sdsc_pkg::ST_ERR;
        else begin
          m_pend = sdsc_pkg::PK_WRITE;
          r.request_valid = 1'b1;
          r.request_write = 1'b1;
          r.request_sector = sec;
        end
      end
      sdsc_pkg::CMD_FLASH: begin
        if (!m_mounted) fill_buffer(8'h00);
        else if (!in_range) fill_buffer(8'hFF);
        else begin
          m_pend = sdsc_pkg::PK_FLASH;
          r.request_valid = 1'b1;
          r.request_sector = sec;
        end
      end
      sdsc_pkg::CMD_INT0, sdsc_pkg::CMD_INT1: model_st &= ~sdsc_pkg::ST_EXT;
      sdsc_pkg::CMD_EXT: model_st |= sdsc_pkg::ST_EXT;
      sdsc_pkg::CMD_MAP: begin
        m_mapped = 1'b1;
        model_st |= sdsc_pkg::ST_MAPPED;
      end
      sdsc_pkg::CMD_UNMAP: begin
        m_mapped = 1'b0;
        model_st &= ~sdsc_pkg::ST_MAPPED;
      end
      default: ;
    endcase
  endfunction

  function automatic reply_t predict_reply(input bus_word_t w);
    reply_t r;
    logic   win, hit;
    int     off, roff;
    r = '0;
    win = w.address >= sdsc_pkg::WIN_LO && w.address <= sdsc_pkg::WIN_HI;
    off = (w.address - sdsc_pkg::WIN_LO) % sdsc_pkg::BUFFER_BYTES;
    hit = w.address >= m_base && (w.address - m_base) < sdsc_pkg::REGISTER_COUNT;
    roff = hit ? w.address - m_base : 0;
    case (w.action)
      sdsc_pkg::ACT_BUS_READ: begin
        if (win) begin
          r.handled = 1'b1;
          r.read_data = m_mapped ? m_buf[off] : 8'hFF;
        end else if (hit) begin
          r.handled = 1'b1;
          r.read_data = (roff == 0) ? model_st : m_regs[roff];
        end
      end
      sdsc_pkg::ACT_BUS_WRITE: begin
        if (win) begin
          r.handled = 1'b1;
          if (m_mapped) m_buf[off] = w.data;
        end else if (hit) begin
          r.handled = 1'b1;
          m_regs[roff] = w.data;
          if (roff == 0) model_command(w.data, r);
        end
      end
      sdsc_pkg::ACT_FILL:
        if (m_pend == sdsc_pkg::PK_READ || m_pend == sdsc_pkg::PK_FLASH)
          m_buf[w.buffer_index] = w.data;
      sdsc_pkg::ACT_FETCH: r.read_data = m_buf[w.buffer_index];
      sdsc_pkg::ACT_DONE: begin
        if (m_pend != sdsc_pkg::PK_NONE && !w.storage_ok) begin
          if (m_pend == sdsc_pkg::PK_FLASH) fill_buffer(8'hFF);
          else model_st |= sdsc_pkg::ST_ERR;
        end
        m_pend = sdsc_pkg::PK_NONE;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_word(input bus_word_t w);
    int gap;
    reply_t r;
    gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    r = predict_reply(w);
    expected_replies = {expected_replies, r};
    in_valid = 1'b1;
    in_action = w.action;
    in_address = w.address;
    in_data = w.data;
    in_buffer_index = w.buffer_index;
    in_storage_ok = w.storage_ok;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_drained;
    while (expected_replies.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [32:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      sdsc_pkg::CFG_BASE: m_base = v[15:0];
      sdsc_pkg::CFG_MOUNTED: m_mounted = v[0];
      sdsc_pkg::CFG_WRITABLE: m_writable = v[0];
      sdsc_pkg::CFG_SECTORS: m_sectors = v;
      default: ;
    endcase
  endtask

  function automatic bus_word_t mk(input logic [2:0] a, input logic [15:0] addr,
                                   input logic [7:0] d, input logic [8:0] bi,
                                   input logic ok);
    bus_word_t w;
    w = '{a, addr, d, bi, ok};
    return w;
  endfunction

  task automatic reg_write(input int off, input logic [7:0] d);
    send_word(mk(sdsc_pkg::ACT_BUS_WRITE, m_base + off[15:0], d, 9'($urandom),
                 1'($urandom)));
  endtask

  task automatic set_sector(input logic [31:0] s);
    for (int i = 0; i < 4; i++) reg_write(i + 1, s[8*i +: 8]);
  endtask

  // result checker
  always @(posedge clk) begin
    reply_t got, exp_r;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_handled, out_read_data, out_request_valid, out_request_write,
              out_request_sector};
      if (expected_replies.size() == 0) begin
        $error("unexpected word: %p", got);
        n_errors++;
      end else begin
        exp_r = expected_replies.pop_front();
        n_checked++;
        if (got.request_valid) n_requests++;
        if (got.handled !== exp_r.handled) begin
          $error("handled exp %0h got %0h", exp_r.handled, got.handled); n_errors++;
        end
        if (got.read_data !== exp_r.read_data) begin
          $error("read_data exp %0h got %0h", exp_r.read_data, got.read_data); n_errors++;
        end
        if (got.request_valid !== exp_r.request_valid) begin
          $error("request_valid exp %0h got %0h", exp_r.request_valid,
                 got.request_valid); n_errors++;
        end
        if (got.request_write !== exp_r.request_write) begin
          $error("request_write exp %0h got %0h", exp_r.request_write,
                 got.request_write); n_errors++;
        end
        if (got.request_sector !== exp_r.request_sector) begin
          $error("request_sector exp %0h got %0h", exp_r.request_sector,
                 got.request_sector); n_errors++;
        end
      end
    end
  end

  // receiver stall: a fresh wait per word, one long hold on request, or none
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
        long_hold = 1'b0;
      end else if (random_out) begin
        n = $urandom_range(0, 15);
        if (n != 0) begin
          out_stall <= 1'b1;
          repeat (n) @(negedge clk);
        end
        out_stall <= 1'b0;
        @(posedge clk);
        while (!(out_valid && !out_stall) && !long_hold && random_out) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog: the idle limit covers sweeps, stalls and the long hold
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("tb_sd_card_sector_controller: done, errors");
      $finish;
    end
  end

  task automatic test_directed;
    write_cfg(sdsc_pkg::CFG_BASE, 33'h0);
    write_cfg(sdsc_pkg::CFG_MOUNTED, 33'h1);
    write_cfg(sdsc_pkg::CFG_WRITABLE, 33'h1);
    write_cfg(sdsc_pkg::CFG_SECTORS, 33'h1_0000_0000);
    send_word(mk(sdsc_pkg::ACT_BUS_READ, 16'h0000, '0, '0, 1'b0));
    send_word(mk(sdsc_pkg::ACT_BUS_READ, sdsc_pkg::WIN_LO, '0, '0, 1'b0));
    reg_write(0, sdsc_pkg::CMD_MAP);
    send_word(mk(sdsc_pkg::ACT_BUS_WRITE, sdsc_pkg::WIN_HI, 8'hA5, '0, 1'b0));
    send_word(mk(sdsc_pkg::ACT_BUS_READ, sdsc_pkg::WIN_HI, '0, '0, 1'b0));
    set_sector(32'hFFFF_FFFF);
    reg_write(0, sdsc_pkg::CMD_READ);
    send_word(mk(sdsc_pkg::ACT_FILL, '0, 8'h5A, 9'h1FF, 1'b0));
    send_word(mk(sdsc_pkg::ACT_DONE, '0, '0, '0, 1'b0));
    reg_write(0, sdsc_pkg::CMD_FLASH);
    send_word(mk(sdsc_pkg::ACT_DONE, '0, '0, '0, 1'b0));
    send_word(mk(sdsc_pkg::ACT_FETCH, '0, '0, 9'h1FF, 1'b0));
    reg_write(0, sdsc_pkg::CMD_WRITE);
    send_word(mk(sdsc_pkg::ACT_DONE, '0, '0, '0, 1'b1));
    reg_write(0, sdsc_pkg::CMD_EXT);
    send_word(mk(sdsc_pkg::ACT_BUS_READ, 16'h0013, '0, '0, 1'b0));
    send_word(mk(sdsc_pkg::ACT_BUS_READ, 16'h0014, '0, '0, 1'b0));
    send_word(mk(3'd7, 16'hFFFF, 8'hFF, 9'h1FF, 1'b1));
    reg_write(0, sdsc_pkg::CMD_RESET1);
    wait_drained();
  endtask

  task automatic test_config_corners;
    write_cfg(sdsc_pkg::CFG_MOUNTED, 33'h0);
    reg_write(0, sdsc_pkg::CMD_READ);
    reg_write(0, sdsc_pkg::CMD_FLASH);
    reg_write(0, sdsc_pkg::CMD_WRITE);
    wait_drained();
    write_cfg(sdsc_pkg::CFG_MOUNTED, 33'h1);
    write_cfg(sdsc_pkg::CFG_SECTORS, 33'h0);
    reg_write(0, sdsc_pkg::CMD_READ);
    reg_write(0, sdsc_pkg::CMD_FLASH);
    send_word(mk(sdsc_pkg::ACT_FETCH, '0, '0, 9'd7, 1'b0));
    wait_drained();
    write_cfg(sdsc_pkg::CFG_SECTORS, 33'h10);
    write_cfg(sdsc_pkg::CFG_WRITABLE, 33'h0);
    reg_write(0, sdsc_pkg::CMD_WRITE);
    reg_write(0, sdsc_pkg::CMD_END1);
    wait_drained();
    write_cfg(sdsc_pkg::CFG_BASE, 33'hDDF8);
    send_word(mk(sdsc_pkg::ACT_BUS_READ, 16'hDDF8, '0, '0, 1'b0));
    send_word(mk(sdsc_pkg::ACT_BUS_READ, 16'hDE00, '0, '0, 1'b0));
    send_word(mk(sdsc_pkg::ACT_BUS_READ, 16'hDDF7, '0, '0, 1'b0));
    wait_drained();
    write_cfg(sdsc_pkg::CFG_BASE, 33'hFFFF);
    send_word(mk(sdsc_pkg::ACT_BUS_READ, 16'hFFFF, '0, '0, 1'b0));
    wait_drained();
  endtask

  // random mix: storage transactions, commands, window and register accesses, any words
  task automatic random_phase(input int n_words);
    logic [7:0] cmds [12];
    cmds = '{sdsc_pkg::CMD_RESET0, sdsc_pkg::CMD_RESET1, sdsc_pkg::CMD_END0,
             sdsc_pkg::CMD_END1, sdsc_pkg::CMD_READ, sdsc_pkg::CMD_WRITE,
             sdsc_pkg::CMD_FLASH, sdsc_pkg::CMD_INT0, sdsc_pkg::CMD_INT1,
             sdsc_pkg::CMD_EXT, sdsc_pkg::CMD_MAP, sdsc_pkg::CMD_UNMAP};
    for (int k = 0; k < n_words; k++) begin
      int pick;
      logic [7:0] cmd;
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        // sector transaction: sector, command, a few fills/fetches, done
        set_sector($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 40));
        cmd = $urandom_range(0, 2) == 0 ? sdsc_pkg::CMD_READ :
              ($urandom_range(0, 1) ? sdsc_pkg::CMD_WRITE : sdsc_pkg::CMD_FLASH);
        // sweeps are slow: most sector numbers land in range
        reg_write(0, cmd);
        repeat ($urandom_range(1, 4))
          send_word(mk($urandom_range(0, 1) ? sdsc_pkg::ACT_FILL : sdsc_pkg::ACT_FETCH,
                       16'($urandom), 8'($urandom), 9'($urandom), 1'b0));
        send_word(mk(sdsc_pkg::ACT_DONE, 16'($urandom), '0, '0,
                     $urandom_range(0, 3) != 0));
        k += 7;
      end else if (pick < 6) begin
        cmd = $urandom_range(0, 5) == 0 ? 8'($urandom) : cmds[$urandom_range(0, 11)];
        if ((cmd == sdsc_pkg::CMD_READ || cmd == sdsc_pkg::CMD_FLASH) &&
            $urandom_range(0, 3) != 0)
          cmd = sdsc_pkg::CMD_MAP;
        reg_write(0, cmd);
      end else if (pick < 8) begin
        send_word(mk(3'($urandom_range(0, 1)),
                     sdsc_pkg::WIN_LO + 16'($urandom_range(0, 511)),
                     8'($urandom), 9'($urandom), 1'($urandom)));
      end else if (pick < 9) begin
        send_word(mk(3'($urandom_range(0, 1)), m_base + 16'($urandom_range(0, 21)),
                     8'($urandom), 9'($urandom), 1'($urandom)));
      end else begin
        send_word(mk(3'($urandom_range(0, 7)), 16'($urandom), 8'($urandom),
                     9'($urandom), 1'($urandom)));
      end
    end
  endtask

  task automatic test_random;
    write_cfg(sdsc_pkg::CFG_BASE, 33'h0100);
    write_cfg(sdsc_pkg::CFG_MOUNTED, 33'h1);
    write_cfg(sdsc_pkg::CFG_WRITABLE, 33'h1);
    write_cfg(sdsc_pkg::CFG_SECTORS, 33'd30);
    random_phase(800);
    wait_drained();
    write_cfg(sdsc_pkg::CFG_BASE, 33'hD000);
    write_cfg(sdsc_pkg::CFG_WRITABLE, 33'h0);
    write_cfg(sdsc_pkg::CFG_SECTORS, 33'h1_0000_0000);
    random_phase(680);
    wait_drained();
  endtask

  task automatic test_backpressure;
    // receiver holds off while the sender keeps offering words
    long_hold = 1'b1;
    for (int i = 0; i < 12; i++)
      send_word(mk(sdsc_pkg::ACT_FETCH, '0, '0, 9'($urandom), 1'b0));
    wait_drained();
    // register reads under random receiver stalls, then wait until everything has come back
    for (int i = 0; i < 8; i++)
      send_word(mk(sdsc_pkg::ACT_BUS_READ, m_base + 16'($urandom_range(0, 19)),
                   '0, '0, 1'b0));
    wait_drained();
    random_out = 1'b0;
    for (int i = 0; i < 20; i++)
      send_word(mk(sdsc_pkg::ACT_FETCH, '0, '0, 9'($urandom), 1'b0));
    wait_drained();
    random_out = 1'b1;
  endtask

  initial begin
    m_base = '0; m_mounted = 1'b0; m_writable = 1'b1; m_sectors = '0;
    model_st = sdsc_pkg::ST_HC; m_mapped = 1'b0; m_pend = sdsc_pkg::PK_NONE;
    for (int i = 0; i < int'(sdsc_pkg::REGISTER_COUNT); i++) m_regs[i] = '0;
    fill_buffer(8'h00);
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_config_corners();
    test_backpressure();
    test_random();
    wait_drained();
    repeat (600) @(negedge clk);
    $display("covered %0d words, %0d results checked, %0d sector requests",
             n_sent, n_checked, n_requests);
    $display("commands, buffer window, storage fills and dones, config extremes, stalls");
    if (n_errors == 0 && expected_replies.size() == 0)
      $display("tb_sd_card_sector_controller: done, clean");
    else
      $display("tb_sd_card_sector_controller: done, errors");
    $finish;
  end

endmodule
